>>> rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Each macro takes a label, an antecedent, a consequent and a message.
// Both use clk_i and the active-low reset rst_ni of the module that expands them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SFD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SFD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sfd_pkg.sv
package sfd_pkg;

  // Frame buffer depth and the widths that follow from it.
  localparam int unsigned FRAME_BYTES = 64;
  localparam int unsigned CNT_W       = $clog2(FRAME_BYTES + 1);
  localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);
  localparam int unsigned MEM_AW      = IDX_W + 1;
  localparam int unsigned CMP_W       = (CNT_W > 7) ? CNT_W : 7;

  // Fixed field widths.
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned RIDX_W    = 6;
  localparam int unsigned OFFSET_W  = 12;
  localparam int unsigned GAIN_W    = 8;
  localparam int unsigned MULT_W    = GAIN_W + 1;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned SUM_W     = SAMPLE_W + 1;
  localparam int unsigned PROD_W    = SUM_W + MULT_W;
  localparam int unsigned GAIN_SHIFT = 2;
  localparam int unsigned WAKE_W    = 23;
  localparam int unsigned SEC_W     = 24;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned TDATA_IN_W  = 16;
  localparam int unsigned TDATA_OUT_W = 88;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'hFFFF;
  localparam logic [WAKE_W-1:0]   WAKE_MIN   = 23'd5;
  localparam logic [WAKE_W-1:0]   WAKE_MAX   = WAKE_W'(32'hFFFF_FFFF / 1000);

  localparam logic OP_RECEIVE    = 1'b0;
  localparam logic OP_READ       = 1'b1;
  localparam logic REPLY_SUMMARY = 1'b0;
  localparam logic REPLY_READ    = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAL_OFFSET = 2'd0,
    CFG_CAL_GAIN   = 2'd1,
    CFG_STORE_EN   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [OFFSET_W-1:0] cal_offset;
    logic [GAIN_W-1:0]   cal_gain_code;
    logic                store_enable;
  } cfg_t;

  // First pipeline stage: frame bookkeeping done, samples offset but not scaled.
  typedef struct packed {
    logic                reply_kind;
    logic [BYTE_W-1:0]   command_byte;
    logic [LEN_W-1:0]    frame_length;
    logic                sample_updated;
    logic                interval_updated;
    logic [WAKE_W-1:0]   wake_seconds;
    logic [SUM_W-1:0]    sum_primary;
    logic [SUM_W-1:0]    sum_secondary;
    logic                read_hit;
    logic [BYTE_W-1:0]   read_data;
    logic [LEN_W-1:0]    stored_length;
    logic                stored_valid;
  } s1_t;

  // Second pipeline stage: samples multiplied by the gain.
  typedef struct packed {
    logic                reply_kind;
    logic [BYTE_W-1:0]   command_byte;
    logic [LEN_W-1:0]    frame_length;
    logic                sample_updated;
    logic                interval_updated;
    logic [WAKE_W-1:0]   wake_seconds;
    logic [PROD_W-1:0]   prod_primary;
    logic [PROD_W-1:0]   prod_secondary;
    logic [BYTE_W-1:0]   read_data;
    logic [LEN_W-1:0]    stored_length;
    logic                stored_valid;
  } s2_t;

  // Result word, laid out exactly as the output tdata (last member lowest).
  typedef struct packed {
    logic                stored_valid;
    logic [LEN_W-1:0]    stored_length;
    logic [BYTE_W-1:0]   read_data;
    logic [WAKE_W-1:0]   wake_seconds;
    logic                interval_updated;
    logic [SAMPLE_W-1:0] secondary_sample;
    logic [SAMPLE_W-1:0] primary_sample;
    logic                sample_updated;
    logic [LEN_W-1:0]    frame_length;
    logic [BYTE_W-1:0]   command_byte;
  } res_t;

endpackage

>>> rtl/sensor_frame_decoder_core.sv
// A result word is registered in the frame control, multiply and output stages before it leaves.
// Throughput: one input word per cycle; each stage holds its word only while the next is full.
// Bytes not marked last give no result; a frame end or a read gives exactly one.
// Reset (rst_ni, asynchronous, active low) empties the pipeline, clears the frame count,
// head bytes and stored-frame status, sets the wake interval to 5 and store_enable to 1.
module sensor_frame_decoder_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata, lowest bit up: frame_byte[7:0], read_index[13:8], zero fill[15:14].
  input  logic [sfd_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
  // tuser: operation (0 receive a byte, 1 read a stored byte).
  input  logic                               s_axis_tuser,
  input  logic                               s_axis_tlast,
  // Output stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata, lowest bit up: command_byte[7:0], frame_length[14:8], sample_updated[15],
  // primary_sample[31:16], secondary_sample[47:32], interval_updated[48],
  // wake_seconds[71:49], read_data[79:72], stored_length[86:80], stored_valid[87].
  output logic [sfd_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
  // tuser: reply_kind (0 frame summary, 1 read reply).
  output logic                               m_axis_tuser,
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [sfd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import sfd_pkg::*;

  // The block is built as three register stages:
  //   frame control  - counts the frame, keeps the first four bytes, writes each byte that fits
  //                    into the receive bank of a two-bank byte memory and reads the stored bank.
  //                    A stored frame is made by swapping the banks, so no copy is needed.
  //                    The offset is added to both raw samples here.
  //   multiply       - each sample sum is multiplied by the gain code plus one.
  //   output         - the product is divided by four, saturated, and held for the sink.
  // Every stage passes its word on when the stage after it is empty or being emptied,
  // so input words keep flowing while a result waits at the output, until all three
  // stages hold result words; then the input stalls as well.

  cfg_t  cfg_q;
  s1_t   s1;
  logic  s1_valid, s1_ready;
  res_t  res;

  // Writes must be issued only while the block is idle; it does not enforce this. All are taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cal_offset    <= '0;
      cfg_q.cal_gain_code <= '0;
      cfg_q.store_enable  <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CAL_OFFSET: cfg_q.cal_offset    <= cfg_data_i[OFFSET_W-1:0];
        CFG_CAL_GAIN:   cfg_q.cal_gain_code <= cfg_data_i[GAIN_W-1:0];
        CFG_STORE_EN:   cfg_q.store_enable  <= cfg_data_i[0];
        default: ;  // Indexes past the register list are ignored.
      endcase
    end
  end

  sfd_frame_ctl u_frame_ctl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .op_i         (s_axis_tuser),
    .byte_i       (s_axis_tdata[7:0]),
    .last_i       (s_axis_tlast),
    .read_index_i (s_axis_tdata[13:8]),
    .s1_valid_o   (s1_valid),
    .s1_ready_i   (s1_ready),
    .s1_o         (s1)
  );

  sfd_cal_pipe u_cal_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .gain_code_i (cfg_q.cal_gain_code),
    .s1_valid_i  (s1_valid),
    .s1_ready_o  (s1_ready),
    .s1_i        (s1),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_o       (res)
  );

  // The result struct is laid out bit for bit as the output word.
  assign m_axis_tdata = res;

endmodule

>>> rtl/sfd_frame_ctl.sv
module sfd_frame_ctl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sfd_pkg::cfg_t                 cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [sfd_pkg::BYTE_W-1:0]    byte_i,
  input  logic                          last_i,
  input  logic [sfd_pkg::RIDX_W-1:0]    read_index_i,
  output logic                          s1_valid_o,
  input  logic                          s1_ready_i,
  output sfd_pkg::s1_t                  s1_o
);
  import sfd_pkg::*;

  // Two banks: one receives the current frame, the other holds the stored frame.
  // Storing a frame swaps the banks instead of copying.
  logic [BYTE_W-1:0] mem [2**MEM_AW];
  logic [BYTE_W-1:0] rdata_q;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [BYTE_W-1:0] head_q [4];
  logic [BYTE_W-1:0] head_d [4];
  logic [BYTE_W-1:0] head_nx [4];
  logic              bank_q, bank_d;
  logic [CNT_W-1:0]  scount_q, scount_d;
  logic              sflag_q, sflag_d;
  logic [WAKE_W-1:0] wake_q, wake_d;
  logic              s1_valid_q;
  s1_t               s1_q, s1_d;

  logic              fire, is_rx, is_rd, frame_end, keep, has_result;
  logic [CNT_W-1:0]  len_nx;
  logic [SEC_W-1:0]  sec;
  logic [WAKE_W-1:0] sec_clamped;
  logic [CMP_W-1:0]  rd_idx_ext;
  logic              rd_hit;
  logic [MEM_AW-1:0] waddr, raddr;

  assign in_ready_o = !s1_valid_q || s1_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign is_rx      = fire && (op_i == OP_RECEIVE);
  assign is_rd      = fire && (op_i == OP_READ);
  assign frame_end  = is_rx && last_i;
  assign has_result = frame_end || is_rd;
  assign keep       = cnt_q < CNT_W'(FRAME_BYTES);
  assign len_nx     = keep ? cnt_q + CNT_W'(1) : cnt_q;

  assign waddr      = {~bank_q, cnt_q[IDX_W-1:0]};
  assign raddr      = {bank_q, IDX_W'(read_index_i)};
  assign rd_idx_ext = CMP_W'(read_index_i);
  assign rd_hit     = rd_idx_ext < CMP_W'(scount_q);

  always_comb begin
    head_nx = head_q;
    if (keep && (cnt_q < CNT_W'(4))) begin
      head_nx[cnt_q[1:0]] = byte_i;
    end
  end

  assign sec = {head_nx[3], head_nx[2], head_nx[1]};

  always_comb begin
    if (sec < SEC_W'(WAKE_MIN)) begin
      sec_clamped = WAKE_MIN;
    end else if (sec > SEC_W'(WAKE_MAX)) begin
      sec_clamped = WAKE_MAX;
    end else begin
      sec_clamped = sec[WAKE_W-1:0];
    end
  end

  always_comb begin
    cnt_d    = cnt_q;
    head_d   = head_q;
    bank_d   = bank_q;
    scount_d = scount_q;
    sflag_d  = sflag_q;
    wake_d   = wake_q;
    if (is_rx) begin
      cnt_d  = len_nx;
      head_d = head_nx;
      if (last_i) begin
        cnt_d  = '0;
        head_d = '{default: '0};
        if (len_nx == CNT_W'(4)) begin
          wake_d = sec_clamped;
        end
        if (cfg_i.store_enable) begin
          bank_d   = ~bank_q;
          scount_d = len_nx;
          sflag_d  = 1'b1;
        end
      end
    end
  end

  always_comb begin
    s1_d = '0;
    if (op_i == OP_READ) begin
      s1_d.reply_kind    = REPLY_READ;
      s1_d.wake_seconds  = wake_q;
      s1_d.read_hit      = rd_hit;
      s1_d.stored_length = LEN_W'(scount_q);
      s1_d.stored_valid  = sflag_q;
    end else begin
      s1_d.reply_kind       = REPLY_SUMMARY;
      s1_d.command_byte     = head_nx[0];
      s1_d.frame_length     = LEN_W'(len_nx);
      s1_d.sample_updated   = len_nx >= CNT_W'(4);
      s1_d.interval_updated = len_nx == CNT_W'(4);
      s1_d.wake_seconds     = wake_d;
      s1_d.sum_primary      = SUM_W'({head_nx[0], head_nx[1]}) + SUM_W'(cfg_i.cal_offset);
      s1_d.sum_secondary    = SUM_W'({head_nx[2], head_nx[3]}) + SUM_W'(cfg_i.cal_offset);
      s1_d.stored_length    = LEN_W'(scount_d);
      s1_d.stored_valid     = sflag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_rx && keep) begin
      mem[waddr] <= byte_i;
    end
    if (is_rd) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      head_q     <= '{default: '0};
      bank_q     <= 1'b0;
      scount_q   <= '0;
      sflag_q    <= 1'b0;
      wake_q     <= WAKE_MIN;
      s1_valid_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      head_q   <= head_d;
      bank_q   <= bank_d;
      scount_q <= scount_d;
      sflag_q  <= sflag_d;
      wake_q   <= wake_d;
      if (has_result) begin
        s1_valid_q <= 1'b1;
      end else if (s1_ready_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (has_result) begin
      s1_q <= s1_d;
    end
  end

  // Read data comes from the registered memory port, or is zero past the stored length.
  always_comb begin
    s1_o           = s1_q;
    s1_o.read_data = s1_q.read_hit ? rdata_q : '0;
  end

  assign s1_valid_o = s1_valid_q;

endmodule

>>> rtl/sfd_cal_pipe.sv
module sfd_cal_pipe (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [sfd_pkg::GAIN_W-1:0]  gain_code_i,
  input  logic                        s1_valid_i,
  output logic                        s1_ready_o,
  input  sfd_pkg::s1_t                s1_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        out_kind_o,
  output sfd_pkg::res_t               out_o
);
  import sfd_pkg::*;

  logic              v2_q, v3_q, rdy2, rdy3;
  s2_t               s2_q, s2_d;
  res_t              res_q, res_d;
  logic              kind_q;
  logic [MULT_W-1:0] mult;

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign s1_ready_o = rdy2;
  assign mult       = MULT_W'(gain_code_i) + MULT_W'(1);

  always_comb begin
    s2_d.reply_kind       = s1_i.reply_kind;
    s2_d.command_byte     = s1_i.command_byte;
    s2_d.frame_length     = s1_i.frame_length;
    s2_d.sample_updated   = s1_i.sample_updated;
    s2_d.interval_updated = s1_i.interval_updated;
    s2_d.wake_seconds     = s1_i.wake_seconds;
    s2_d.prod_primary     = PROD_W'(s1_i.sum_primary) * PROD_W'(mult);
    s2_d.prod_secondary   = PROD_W'(s1_i.sum_secondary) * PROD_W'(mult);
    s2_d.read_data        = s1_i.read_data;
    s2_d.stored_length    = s1_i.stored_length;
    s2_d.stored_valid     = s1_i.stored_valid;
  end

  function automatic logic [SAMPLE_W-1:0] scale_sat(logic [PROD_W-1:0] prod, logic ok);
    logic [PROD_W-1:0] q;
    q = prod >> GAIN_SHIFT;
    if (!ok) begin
      return '0;
    end else if (q > PROD_W'(SAMPLE_MAX)) begin
      return SAMPLE_MAX;
    end
    return q[SAMPLE_W-1:0];
  endfunction

  always_comb begin
    res_d.command_byte     = s2_q.command_byte;
    res_d.frame_length     = s2_q.frame_length;
    res_d.sample_updated   = s2_q.sample_updated;
    res_d.primary_sample   = scale_sat(s2_q.prod_primary, s2_q.sample_updated);
    res_d.secondary_sample = scale_sat(s2_q.prod_secondary, s2_q.sample_updated);
    res_d.interval_updated = s2_q.interval_updated;
    res_d.wake_seconds     = s2_q.wake_seconds;
    res_d.read_data        = s2_q.read_data;
    res_d.stored_length    = s2_q.stored_length;
    res_d.stored_valid     = s2_q.stored_valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_q <= s1_valid_i;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && s1_valid_i) begin
      s2_q <= s2_d;
    end
    if (rdy3 && v2_q) begin
      res_q  <= res_d;
      kind_q <= s2_q.reply_kind;
    end
  end

  assign out_valid_o = v3_q;
  assign out_kind_o  = kind_q;
  assign out_o       = res_q;

endmodule

>>> rtl/sfd_checker.sv
`include "assert_macros.svh"

module sfd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [sfd_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser
);
  import sfd_pkg::*;

  res_t res;
  logic read_out, summary_out, no_samples;
  logic summary_clear, summary_ok, wake_ok, samples_clear;

  assign res         = res_t'(m_axis_tdata);
  assign read_out    = m_axis_tvalid && (m_axis_tuser == REPLY_READ);
  assign summary_out = m_axis_tvalid && (m_axis_tuser == REPLY_SUMMARY);
  assign no_samples  = m_axis_tvalid && !res.sample_updated;

  assign summary_clear = (res.command_byte == '0) && (res.frame_length == '0) &&
                         !res.sample_updated && (res.primary_sample == '0) &&
                         (res.secondary_sample == '0) && !res.interval_updated;
  assign summary_ok    = (res.read_data == '0) && (res.frame_length != '0);
  assign wake_ok       = (res.wake_seconds >= WAKE_MIN) && (res.wake_seconds <= WAKE_MAX);
  assign samples_clear = (res.primary_sample == '0) && (res.secondary_sample == '0);

  // A stalled result word stays on offer.
  `SFD_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")

  // A read reply carries no frame summary.
  `SFD_ASSERT_IMP(a_read_clean, read_out, summary_clear, "read reply carries summary fields")

  // A summary has a kept length and no read data.
  `SFD_ASSERT_IMP(a_summary_shape, summary_out, summary_ok, "malformed frame summary")

  // The wake interval never leaves its clamp range.
  `SFD_ASSERT_IMP(a_wake_range, m_axis_tvalid, wake_ok, "wake interval out of range")

  // Samples are zero unless flagged as updated.
  `SFD_ASSERT_IMP(a_sample_zero, no_samples, samples_clear, "samples without sample_updated")

endmodule

bind sensor_frame_decoder_core sfd_checker u_sfd_checker (.*);

>>> verif/tb_sensor_frame_decoder_core.sv
module tb_sensor_frame_decoder_core;
  import sfd_pkg::*;

  // Cycles with no accepted word on any channel before the run is declared hung.
  // The longest legitimate quiet spell is the deliberate output hold-off below.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // Extra wait once the last awaited result has arrived.
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned MAX_GAP        = 16;
  localparam int unsigned RANDOM_WORDS   = 1050;
  localparam int unsigned PHASE_WORDS    = 150;
  localparam int unsigned HOLD_CYCLES    = 150;
  localparam int unsigned REPORT_LIMIT   = 10;
  // The index field is two bits wide, so one index names no register at all.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // One awaited result: the reply kind travels in tuser, the rest in tdata.
  typedef struct {
    logic kind;
    res_t word;
  } reply_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  sensor_frame_decoder_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Mirror of the decoder: register copies, the frame being received and the
  // frame held for readback.
  logic [OFFSET_W-1:0] cal_offset_q;
  logic [GAIN_W-1:0]   cal_gain_q;
  logic                store_en_q;
  logic [LEN_W-1:0]    rx_len;
  logic [BYTE_W-1:0]   head_q [4];
  logic [BYTE_W-1:0]   rx_bytes [FRAME_BYTES];
  logic [BYTE_W-1:0]   kept_bytes [FRAME_BYTES];
  logic [LEN_W-1:0]    kept_len;
  logic                kept_flag;
  logic [WAKE_W-1:0]   wake_s;

  reply_t pending_replies [$];

  bit          src_idle;
  bit          sink_idle;
  int unsigned sink_hold;
  int unsigned mismatches      = 0;
  int unsigned words_sent      = 0;
  int unsigned frames_ended    = 0;
  int unsigned reads_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned settings_used   = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Offset, scale by gain plus one, drop two fraction bits, then saturate.
  function automatic logic [SAMPLE_W-1:0] scale_sample(input logic [15:0] raw);
    logic [31:0] scaled;
    scaled = ((32'(raw) + 32'(cal_offset_q)) * (32'(cal_gain_q) + 32'd1)) / 4;
    return (scaled > 32'(SAMPLE_MAX)) ? SAMPLE_MAX : scaled[SAMPLE_W-1:0];
  endfunction

  // Works out the reply, if any, to one accepted input word and queues it.
  function automatic void predict_word(input logic op, input logic [BYTE_W-1:0] din,
                                       input logic last, input logic [RIDX_W-1:0] ridx);
    reply_t            r;
    logic [SEC_W-1:0]  secs;
    int                i;
    r.kind = REPLY_READ;
    r.word = '0;
    if (op == OP_READ) begin
      // Positions at or past the stored length read as zero.
      r.word.read_data     = (ridx < kept_len) ? kept_bytes[ridx] : '0;
      r.word.wake_seconds  = wake_s;
      r.word.stored_length = kept_len;
      r.word.stored_valid  = kept_flag;
      pending_replies.push_back(r);
      reads_sent++;
    end else begin
      // Bytes past the buffer depth are dropped but the frame goes on.
      if (rx_len < FRAME_BYTES) begin
        rx_bytes[rx_len] = din;
        if (rx_len < 4) head_q[rx_len] = din;
        rx_len++;
      end
      if (last) begin
        // Only a frame of exactly four bytes carries a new wake interval.
        if (rx_len == 4) begin
          secs = {head_q[3], head_q[2], head_q[1]};
          if (secs < WAKE_MIN) wake_s = WAKE_MIN;
          else if (secs > WAKE_MAX) wake_s = WAKE_MAX;
          else wake_s = secs[WAKE_W-1:0];
          r.word.interval_updated = 1'b1;
        end
        if (store_en_q) begin
          for (i = 0; i < rx_len; i++) kept_bytes[i] = rx_bytes[i];
          kept_len  = rx_len;
          kept_flag = 1'b1;
        end
        if (rx_len >= 4) begin
          r.word.sample_updated   = 1'b1;
          r.word.primary_sample   = scale_sample({head_q[0], head_q[1]});
          r.word.secondary_sample = scale_sample({head_q[2], head_q[3]});
        end
        r.kind                = REPLY_SUMMARY;
        r.word.command_byte   = head_q[0];
        r.word.frame_length   = rx_len;
        r.word.wake_seconds   = wake_s;
        r.word.stored_length  = kept_len;
        r.word.stored_valid   = kept_flag;
        pending_replies.push_back(r);
        rx_len = '0;
        for (i = 0; i < 4; i++) head_q[i] = '0;
        frames_ended++;
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] seen);
    if (seen !== want) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("result %0d, %s: expected %0h, got %0h", results_checked, name, want, seen);
    end
  endfunction

  // Compares every result word that leaves the block with the oldest one awaited.
  initial begin : result_checker
    reply_t want_r;
    res_t   got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata);
        if (pending_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result word: tuser %0b, tdata %h", m_axis_tuser, m_axis_tdata);
        end else begin
          want_r = pending_replies.pop_front();
          results_checked++;
          check_field("reply_kind",       want_r.kind,                  m_axis_tuser);
          check_field("command_byte",     want_r.word.command_byte,     got.command_byte);
          check_field("frame_length",     want_r.word.frame_length,     got.frame_length);
          check_field("sample_updated",   want_r.word.sample_updated,   got.sample_updated);
          check_field("primary_sample",   want_r.word.primary_sample,   got.primary_sample);
          check_field("secondary_sample", want_r.word.secondary_sample, got.secondary_sample);
          check_field("interval_updated", want_r.word.interval_updated, got.interval_updated);
          check_field("wake_seconds",     want_r.word.wake_seconds,     got.wake_seconds);
          check_field("read_data",        want_r.word.read_data,        got.read_data);
          check_field("stored_length",    want_r.word.stored_length,    got.stored_length);
          check_field("stored_valid",     want_r.word.stored_valid,     got.stored_valid);
        end
      end
    end
  end

  // Output side: after each accepted word the receiver may pause for a drawn
  // number of cycles; a requested hold-off keeps it away for a long stretch.
  initial begin : result_sink
    int unsigned gap;
    gap = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) gap = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no word moved for %0d cycles, %0d results outstanding",
             quiet, pending_replies.size());
    $display("[sensor_frame_decoder_core] ERROR");
    $finish;
  end

  // Offers one input word after an optional gap and waits for the handshake.
  task automatic send_word(input logic op, input logic [BYTE_W-1:0] din, input logic last,
                           input logic [RIDX_W-1:0] ridx);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tlast  <= last;
    s_axis_tdata  <= {2'b00, ridx, din};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_word(op, din, last, ridx);
    words_sent++;
  endtask

  // The unused fields of each word, but for the zero fill, carry random values all the same.
  task automatic send_byte(input logic [BYTE_W-1:0] din, input logic last);
    send_word(OP_RECEIVE, din, last, RIDX_W'($urandom_range(0, 63)));
  endtask

  task automatic send_read(input logic [RIDX_W-1:0] ridx);
    send_word(OP_READ, BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 1) == 1, ridx);
  endtask

  task automatic send_quad(input logic [7:0] b0, input logic [7:0] b1,
                           input logic [7:0] b2, input logic [7:0] b3);
    send_byte(b0, 1'b0);
    send_byte(b1, 1'b0);
    send_byte(b2, 1'b0);
    send_byte(b3, 1'b1);
  endtask

  // Stops offering words, lets every awaited result arrive and the pipeline empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_CAL_OFFSET: cal_offset_q = val[OFFSET_W-1:0];
      CFG_CAL_GAIN:   cal_gain_q   = val[GAIN_W-1:0];
      CFG_STORE_EN:   store_en_q   = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] offset,
                                input logic [CFG_DATA_W-1:0] gain, input logic store);
    settle();
    write_reg(CFG_CAL_OFFSET, offset);
    write_reg(CFG_CAL_GAIN, gain);
    write_reg(CFG_STORE_EN, {11'($urandom_range(0, 2047)), store});
    settings_used++;
  endtask

  // Reads mostly land inside the stored frame, the rest anywhere.
  function automatic logic [RIDX_W-1:0] pick_read_index();
    if (kept_len > 0 && $urandom_range(0, 3) != 0)
      return RIDX_W'($urandom_range(0, kept_len - 1));
    return RIDX_W'($urandom_range(0, 63));
  endfunction

  function automatic int unsigned pick_frame_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return 4;
    if (r < 45) return $urandom_range(1, 3);
    if (r < 80) return $urandom_range(5, 16);
    if (r < 92) return $urandom_range(17, FRAME_BYTES);
    return $urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 8);
  endfunction

  task automatic send_random_frame(input int unsigned len);
    int unsigned i;
    logic [7:0]  b;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) send_read(pick_read_index());
      b = 8'($urandom_range(0, 255));
      // Keep the top interval byte small now and then so that unclamped values occur.
      if (len == 4 && i == 3 && $urandom_range(0, 1) == 1) b = 8'($urandom_range(0, 8'h42));
      send_byte(b, i == len - 1);
    end
  endtask

  // Reads before anything is stored return zero data and an empty store.
  task automatic test_empty_store_reads();
    send_read(6'd0);
    send_read(6'd63);
  endtask

  // One- and three-byte frames: command only, no samples, interval untouched.
  task automatic test_short_frames();
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_read(6'd2);
    send_read(6'd3);
  endtask

  // Four-byte frames under the interval floor, over its ceiling and in range,
  // with the calibration at its reset, largest and smallest settings.
  task automatic test_wake_and_calibration();
    send_quad(8'h12, 8'h00, 8'h00, 8'h00);
    apply_settings(12'hFFF, 12'hFFF, 1'b1);
    write_reg(CFG_UNUSED, 12'hABC);
    send_quad(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    apply_settings(12'h000, 12'hF00, 1'b1);
    send_quad(8'h01, 8'h10, 8'h27, 8'h00);
  endtask

  // A read in the middle of a frame must leave the frame being received alone.
  task automatic test_read_mid_frame();
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_read(6'd1);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b1);
    send_read(6'd3);
  endtask

  // With storing off a five-byte frame is reported but the older frame stays.
  task automatic test_store_disabled();
    apply_settings(12'd100, 12'd3, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b0);
    send_byte(8'h55, 1'b1);
    send_read(6'd0);
    send_read(6'd4);
    apply_settings(12'd100, 12'd3, 1'b1);
  endtask

  // Sixty-six bytes: the length saturates and the last stored position is readable.
  task automatic test_overlong_frame();
    int unsigned i;
    for (i = 0; i < FRAME_BYTES + 2; i++) send_byte(8'(i) ^ 8'h5A, i == FRAME_BYTES + 1);
    send_read(6'd63);
    send_read(6'd0);
  endtask

  // The receiver stays away while the sender streams on, so the pipeline fills
  // and the input must stall without losing or reordering anything.
  task automatic test_output_backpressure();
    settle();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    sink_hold = HOLD_CYCLES;
    repeat (12) begin
      send_random_frame(4);
      send_read(pick_read_index());
    end
    settle();
  endtask

  // Phases of random traffic, each under fresh register values and idling mode.
  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned start;
    logic [CFG_DATA_W-1:0] offset;
    logic [CFG_DATA_W-1:0] gain;
    for (phase = 0; phase < RANDOM_WORDS / PHASE_WORDS; phase++) begin
      case ($urandom_range(0, 3))
        0:       offset = '0;
        1:       offset = '1;
        default: offset = CFG_DATA_W'($urandom_range(0, 4095));
      endcase
      gain = CFG_DATA_W'($urandom_range(0, 4095));
      case ($urandom_range(0, 3))
        0:       gain[GAIN_W-1:0] = '0;
        1:       gain[GAIN_W-1:0] = '1;
        default: ;
      endcase
      apply_settings(offset, gain, $urandom_range(0, 4) != 0);
      // The first phase runs flat out on both sides.
      src_idle  = (phase != 0) && ($urandom_range(0, 3) != 0);
      sink_idle = (phase != 0) && ($urandom_range(0, 3) != 0);
      start = words_sent;
      while (words_sent - start < PHASE_WORDS) begin
        if ($urandom_range(0, 3) == 0) send_read(pick_read_index());
        else send_random_frame(pick_frame_len());
      end
    end
  endtask

  initial begin : stimulus
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    s_axis_tlast  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    // Predictor state as the block comes out of reset.
    cal_offset_q = '0;
    cal_gain_q   = '0;
    store_en_q   = 1'b1;
    rx_len       = '0;
    head_q       = '{default: '0};
    kept_len     = '0;
    kept_flag    = 1'b0;
    wake_s       = WAKE_MIN;
    src_idle     = 1'b0;
    sink_idle    = 1'b0;
    sink_hold    = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_store_reads();
    test_short_frames();
    test_wake_and_calibration();
    test_read_mid_frame();
    test_store_disabled();
    test_overlong_frame();
    test_output_backpressure();
    test_random_traffic();
    settle();

    $display("Sent %0d input words (%0d frames ended, %0d reads); %0d results checked.",
             words_sent, frames_ended, reads_sent, results_checked);
    $display("Used %0d register settings with random idling and one long output hold-off.",
             settings_used);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("[sensor_frame_decoder_core] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_replies.size());
      $display("[sensor_frame_decoder_core] ERROR");
    end
    $finish;
  end

endmodule
